// File: rtl/cfc_pkg.sv
// ----------------------------------------------------------------------------
// CRC-32 frame checker package
// Shared types, status codes, frame constants and the byte-wide CRC update.
// ----------------------------------------------------------------------------
`default_nettype none

package cfc_pkg;

  localparam int unsigned HEADER_BYTES    = 12;
  localparam int unsigned CRC_BYTES       = 4;
  localparam int unsigned MIN_FRAME_BYTES = 4 + 4 + 4 + 4;
  localparam int unsigned POS_WIDTH       = 33;

  localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_XOROUT  = 32'hFFFF_FFFF;
  localparam logic [31:0] VERSION_RST = 32'd1;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_SHORT   = 2'd1,
    STATUS_VERSION = 2'd2,
    STATUS_CRC     = 2'd3
  } frame_status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_end;
  } item_t;

  typedef struct packed {
    logic [7:0]         payload_byte;
    logic               frame_done;
    frame_status_t      frame_status;
    logic signed [31:0] message_id;
  } result_t;

  function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  data);
    logic [31:0] crc;
    crc = crc_in ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
    end
    return crc;
  endfunction

endpackage

`default_nettype wire

// File: rtl/cfc_if.sv
// ----------------------------------------------------------------------------
// CRC-32 frame checker channels
// Valid/ready channels for incoming bytes, results and the version register.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       buffer_end;

  modport source (output valid, output data_byte, output buffer_end, input ready);
  modport sink   (input valid, input data_byte, input buffer_end, output ready);
endinterface

interface cfc_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         payload_byte;
  logic               frame_done;
  logic [1:0]         frame_status;
  logic signed [31:0] message_id;

  modport source (output valid, output payload_byte, output frame_done,
                  output frame_status, output message_id, input ready);
  modport sink   (input valid, input payload_byte, input frame_done,
                  input frame_status, input message_id, output ready);
endinterface

interface cfc_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] expected_version;

  modport source (output valid, output expected_version, input ready);
  modport sink   (input valid, input expected_version, output ready);
endinterface

`default_nettype wire

// File: rtl/cfc_parser.sv
// ----------------------------------------------------------------------------
// CRC-32 frame parser
// Holds the frame state, decodes one byte per step and forms its result.
// ----------------------------------------------------------------------------
`default_nettype none

module cfc_parser (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           step,
  input  wire cfc_pkg::item_t item,
  input  wire logic [31:0]    expected_version,
  output cfc_pkg::result_t    res,
  output logic                res_valid
);
  import cfc_pkg::*;

  logic [POS_WIDTH-1:0] pos, pos_next, pos_inc;
  logic [31:0] version_word, version_word_next;
  logic [31:0] id_word, id_word_next;
  logic [31:0] payload_length, payload_length_next;
  logic [31:0] running_crc, running_crc_next;
  logic [31:0] received_crc, received_crc_next;

  logic [POS_WIDTH-1:0] body_end;
  logic [POS_WIDTH:0]   crc_end;
  logic [POS_WIDTH:0]   need;
  logic [1:0]           crc_lane;
  logic [31:0]          crc_calc;
  logic                 payload_out;
  frame_status_t        status;

  always_comb begin
    body_end = POS_WIDTH'(HEADER_BYTES) + {1'b0, payload_length};
    crc_end  = {1'b0, body_end} + (POS_WIDTH+1)'(CRC_BYTES);
    crc_lane = pos[1:0] - payload_length[1:0];
    crc_calc = crc32_byte(running_crc, item.data_byte);
    pos_inc  = (&pos) ? pos : pos + POS_WIDTH'(1);

    version_word_next   = version_word;
    id_word_next        = id_word;
    payload_length_next = payload_length;
    running_crc_next    = running_crc;
    received_crc_next   = received_crc;
    payload_out         = 1'b0;

    priority if (pos < POS_WIDTH'(HEADER_BYTES)) begin
      priority if (pos < POS_WIDTH'(4)) begin
        version_word_next[pos[1:0]*8 +: 8] = version_word[pos[1:0]*8 +: 8] | item.data_byte;
      end else if (pos < POS_WIDTH'(8)) begin
        id_word_next[pos[1:0]*8 +: 8] = id_word[pos[1:0]*8 +: 8] | item.data_byte;
      end else begin
        payload_length_next[pos[1:0]*8 +: 8] =
          payload_length[pos[1:0]*8 +: 8] | item.data_byte;
      end
      running_crc_next = crc_calc;
    end else if (pos < body_end) begin
      running_crc_next = crc_calc;
      payload_out      = 1'b1;
    end else if ({1'b0, pos} < crc_end) begin
      received_crc_next[crc_lane*8 +: 8] = received_crc[crc_lane*8 +: 8] | item.data_byte;
    end

    need = (POS_WIDTH+1)'(MIN_FRAME_BYTES) + {2'b00, payload_length_next};

    priority if (pos_inc < POS_WIDTH'(MIN_FRAME_BYTES)) begin
      status = STATUS_SHORT;
    end else if (version_word_next != expected_version) begin
      status = STATUS_VERSION;
    end else if ({1'b0, pos_inc} < need) begin
      status = STATUS_SHORT;
    end else if ((running_crc_next ^ CRC_XOROUT) != received_crc_next) begin
      status = STATUS_CRC;
    end else begin
      status = STATUS_OK;
    end

    pos_next = pos_inc;

    res_valid = step && (item.buffer_end || payload_out);
    if (item.buffer_end) begin
      res.payload_byte = 8'd0;
      res.frame_done   = 1'b1;
      res.frame_status = status;
      res.message_id   = (status == STATUS_OK) ? id_word_next : 32'sd0;
    end else begin
      res.payload_byte = item.data_byte;
      res.frame_done   = 1'b0;
      res.frame_status = STATUS_OK;
      res.message_id   = 32'sd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && item.buffer_end)) begin
      pos            <= '0;
      version_word   <= '0;
      id_word        <= '0;
      payload_length <= '0;
      running_crc    <= CRC_INIT;
      received_crc   <= '0;
    end else if (step) begin
      pos            <= pos_next;
      version_word   <= version_word_next;
      id_word        <= id_word_next;
      payload_length <= payload_length_next;
      running_crc    <= running_crc_next;
      received_crc   <= received_crc_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/crc32_frame_checker.sv
// ----------------------------------------------------------------------------
// CRC-32 frame checker
// Parses length-prefixed frames byte by byte, passes the payload through and
// reports the frame status, with the message id of a good frame, on the buffer's last byte.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while results are taken; the parser updates the CRC a byte at a time.
// The input register holds an accepted byte until the parser takes it; its result is then registered.
// Bytes past the CRC word and header bytes give no result.
// Reset clears the frame state and sets the expected version to 1.
`default_nettype none

module crc32_frame_checker (
  input  wire logic  clk,
  input  wire logic  rst,
  cfc_in_if.sink     frame_in,
  cfc_out_if.source  result_out,
  cfc_cfg_if.sink    cfg
);
  import cfc_pkg::*;

  logic        in_valid;
  item_t       in_item;
  logic        out_valid;
  result_t     out_res;
  logic [31:0] expected_version;

  logic        advance;
  result_t     res;
  logic        res_valid;

  assign advance        = in_valid && (!out_valid || result_out.ready);
  assign frame_in.ready = !in_valid || advance;
  assign cfg.ready      = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_version <= VERSION_RST;
    end else if (cfg.valid) begin
      expected_version <= cfg.expected_version;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (frame_in.ready) begin
      in_valid <= frame_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_in.valid && frame_in.ready) begin
      in_item.data_byte  <= frame_in.data_byte;
      in_item.buffer_end <= frame_in.buffer_end;
    end
  end

  cfc_parser u_parser (
    .clk              (clk),
    .rst              (rst),
    .step             (advance),
    .item             (in_item),
    .expected_version (expected_version),
    .res              (res),
    .res_valid        (res_valid)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res <= res;
    end
  end

  assign result_out.valid        = out_valid;
  assign result_out.payload_byte = out_res.payload_byte;
  assign result_out.frame_done   = out_res.frame_done;
  assign result_out.frame_status = out_res.frame_status;
  assign result_out.message_id   = out_res.message_id;

  // A payload result carries no status and no id.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_res.frame_done) |->
      (out_res.frame_status == STATUS_OK && out_res.message_id == 32'sd0))
    else $error("payload result with status or id set");

  // A failed frame never exposes its id.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.frame_done && out_res.frame_status != STATUS_OK) |->
      (out_res.message_id == 32'sd0))
    else $error("failed frame reports a message id");

  // A held input byte stays intact until the parser takes it.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> (in_valid && $stable(in_item)))
    else $error("input register lost a byte");

endmodule

`default_nettype wire

// File: test/crc32_frame_checker_tb.sv
// ----------------------------------------------------------------------------
// CRC-32 frame checker testbench
// Streams length-prefixed frames into the checker with random gaps and result
// stalls. A byte-level predictor of the parser and its CRC works out every
// payload byte and frame status, and each result is checked against it. The
// expected version is rewritten between phases, including both extremes.
// ----------------------------------------------------------------------------
module crc32_frame_checker_tb;
  import cfc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_BYTES = 330;

  logic clk;
  logic rst;

  cfc_in_if  in_ch();
  cfc_out_if out_ch();
  cfc_cfg_if cfg_ch();

  crc32_frame_checker u_dut (
    .clk        (clk),
    .rst        (rst),
    .frame_in   (in_ch),
    .result_out (out_ch),
    .cfg        (cfg_ch)
  );

  item_t       bytes_to_send[$];
  result_t     results_due[$];
  int unsigned bytes_queued;
  int unsigned bytes_taken;
  int unsigned failures;
  int unsigned cycle_count;

  int unsigned send_gap;
  bit          send_calm;
  int unsigned take_stall;
  bit          take_calm;

  logic [31:0] version_reg;
  logic [32:0] rx_pos;
  logic [31:0] rx_version;
  logic [31:0] rx_id;
  logic [31:0] rx_length;
  logic [31:0] rx_crc;
  logic [31:0] rx_crc_word;

  always #10 clk = ~clk;

  function automatic logic [31:0] crc_update(input logic [31:0] crc, input logic [7:0] b);
    logic feedback;
    int   i;
    for (i = 0; i < 8; i++) begin
      feedback = crc[0] ^ b[i];
      crc = {1'b0, crc[31:1]} ^ (feedback ? CRC_POLY : 32'd0);
    end
    return crc;
  endfunction

  function automatic void clear_frame_state();
    rx_pos      = '0;
    rx_version  = '0;
    rx_id       = '0;
    rx_length   = '0;
    rx_crc      = CRC_INIT;
    rx_crc_word = '0;
  endfunction

  function automatic void track_frame_byte(input logic [7:0] b, input logic last);
    logic [33:0] body_end;
    logic [33:0] need;
    logic [33:0] offs;
    logic        is_payload;
    result_t     r;
    body_end   = 34'(HEADER_BYTES) + 34'(rx_length);
    is_payload = 1'b0;
    if (rx_pos < 33'(HEADER_BYTES)) begin
      if (rx_pos < 33'd4) begin
        rx_version |= 32'(b) << (8 * rx_pos[1:0]);
      end else if (rx_pos < 33'd8) begin
        rx_id |= 32'(b) << (8 * rx_pos[1:0]);
      end else begin
        rx_length |= 32'(b) << (8 * rx_pos[1:0]);
      end
      rx_crc = crc_update(rx_crc, b);
    end else if ({1'b0, rx_pos} < body_end) begin
      rx_crc     = crc_update(rx_crc, b);
      is_payload = 1'b1;
    end else if ({1'b0, rx_pos} < body_end + 34'(CRC_BYTES)) begin
      offs = {1'b0, rx_pos} - body_end;
      rx_crc_word |= 32'(b) << (8 * offs[1:0]);
    end
    if (rx_pos != '1) rx_pos = rx_pos + 33'd1;

    r = '0;
    if (last) begin
      need         = body_end + 34'(CRC_BYTES);
      r.frame_done = 1'b1;
      if (rx_pos < 33'(MIN_FRAME_BYTES)) begin
        r.frame_status = STATUS_SHORT;
      end else if (rx_version != version_reg) begin
        r.frame_status = STATUS_VERSION;
      end else if ({1'b0, rx_pos} < need) begin
        r.frame_status = STATUS_SHORT;
      end else if ((rx_crc ^ CRC_XOROUT) != rx_crc_word) begin
        r.frame_status = STATUS_CRC;
      end else begin
        r.frame_status = STATUS_OK;
        r.message_id   = rx_id;
      end
      results_due.push_back(r);
      clear_frame_state();
    end else if (is_payload) begin
      r.payload_byte = b;
      results_due.push_back(r);
    end
  endfunction

  // Builds header, payload and CRC word; the CRC may be spoilt, trailing bytes
  // added and the buffer cut short. Returns the number of bytes queued.
  function automatic int unsigned queue_frame(input logic [31:0] ver, input logic [31:0] id,
                                              input logic [31:0] len,
                                              input int unsigned n_payload, input bit spoil_crc,
                                              input int unsigned n_trail,
                                              input int unsigned cut);
    logic [7:0]  frame_bytes[$];
    logic [31:0] crc;
    item_t       it;
    int          k;
    for (k = 0; k < 4; k++) frame_bytes.push_back(ver[8*k +: 8]);
    for (k = 0; k < 4; k++) frame_bytes.push_back(id[8*k +: 8]);
    for (k = 0; k < 4; k++) frame_bytes.push_back(len[8*k +: 8]);
    for (k = 0; k < n_payload; k++) frame_bytes.push_back(8'($urandom_range(0, 255)));
    crc = CRC_INIT;
    foreach (frame_bytes[k]) crc = crc_update(crc, frame_bytes[k]);
    crc ^= CRC_XOROUT;
    if (spoil_crc) crc ^= 32'd1 << $urandom_range(0, 31);
    for (k = 0; k < 4; k++) frame_bytes.push_back(crc[8*k +: 8]);
    for (k = 0; k < n_trail; k++) frame_bytes.push_back(8'($urandom_range(0, 255)));
    if (cut != 0) begin
      while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
    end
    foreach (frame_bytes[k]) begin
      it.data_byte  = frame_bytes[k];
      it.buffer_end = (k == frame_bytes.size() - 1);
      bytes_to_send.push_back(it);
    end
    bytes_queued += frame_bytes.size();
    return frame_bytes.size();
  endfunction

  task automatic wait_until_idle();
    do @(posedge clk);
    while (bytes_taken != bytes_queued || results_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_version(input logic [31:0] value);
    cfg_ch.expected_version <= value;
    cfg_ch.valid            <= 1'b1;
    do @(posedge clk);
    while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    version_reg = value;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("crc32_frame_checker: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    item_t next_item;
    if (rst) begin
      in_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        track_frame_byte(in_ch.data_byte, in_ch.buffer_end);
        bytes_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap != 0 || bytes_to_send.size() == 0) begin
          in_ch.valid <= 1'b0;
          if (send_gap != 0) send_gap--;
        end else begin
          next_item = bytes_to_send.pop_front();
          in_ch.data_byte  <= next_item.data_byte;
          in_ch.buffer_end <= next_item.buffer_end;
          in_ch.valid      <= 1'b1;
          if ($urandom_range(0, 49) == 0) send_calm = !send_calm;
          send_gap = send_calm ? 0 : $urandom_range(0, 10);
        end
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
      take_stall = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (results_due.size() == 0) begin
          failures++;
          $display("%0t: unexpected result: payload %h done %b status %0d id %h", $time,
                   out_ch.payload_byte, out_ch.frame_done, out_ch.frame_status,
                   out_ch.message_id);
        end else begin
          want = results_due.pop_front();
          if (out_ch.payload_byte !== want.payload_byte ||
              out_ch.frame_done !== want.frame_done ||
              out_ch.frame_status !== want.frame_status ||
              out_ch.message_id !== want.message_id) begin
            failures++;
            $display("%0t: expected payload %h done %b status %0d id %h, got %h %b %0d %h",
                     $time, want.payload_byte, want.frame_done, want.frame_status,
                     want.message_id, out_ch.payload_byte, out_ch.frame_done,
                     out_ch.frame_status, out_ch.message_id);
          end
        end
        if ($urandom_range(0, 49) == 0) take_calm = !take_calm;
        take_stall = take_calm ? 0 : $urandom_range(0, 10);
      end
      if (take_stall != 0) begin
        out_ch.ready <= 1'b0;
        take_stall--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    logic [31:0] settings[5];
    logic [31:0] ver;
    logic [31:0] len;
    int unsigned phase_bytes;
    int unsigned n_payload;
    int unsigned n_trail;
    int unsigned cut;
    int unsigned pick;
    int unsigned n;
    bit          spoil;
    item_t       it;
    int          k;

    clk                     = 1'b0;
    rst                     = 1'b1;
    in_ch.valid             = 1'b0;
    in_ch.data_byte         = '0;
    in_ch.buffer_end        = 1'b0;
    out_ch.ready            = 1'b0;
    cfg_ch.valid            = 1'b0;
    cfg_ch.expected_version = '0;
    bytes_queued            = 0;
    bytes_taken             = 0;
    failures                = 0;
    cycle_count             = 0;
    send_calm               = 1'b0;
    take_calm               = 1'b0;
    version_reg             = VERSION_RST;
    clear_frame_state();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    void'(queue_frame(VERSION_RST, 32'd0, 32'd0, 0, 1'b0, 0, 1));
    void'(queue_frame(VERSION_RST, 32'h8000_0000, 32'd0, 0, 1'b0, 0, 0));
    void'(queue_frame(VERSION_RST, 32'h7FFF_FFFF, 32'd3, 3, 1'b0, 2, 0));
    void'(queue_frame(32'd2, 32'h1234_5678, 32'd2, 2, 1'b0, 0, 0));
    void'(queue_frame(VERSION_RST, 32'd5, 32'd8, 8, 1'b0, 0, 17));
    void'(queue_frame(VERSION_RST, 32'd6, 32'd1, 1, 1'b1, 0, 0));
    void'(queue_frame(VERSION_RST, 32'd7, 32'hFFFF_FFFF, 6, 1'b0, 0, 0));
    void'(queue_frame(32'hFFFF_FFFE, 32'd8, 32'h8000_0000, 2, 1'b0, 0, 0));
    void'(queue_frame(VERSION_RST, 32'd9, 32'd0, 0, 1'b0, 0, 15));
    void'(queue_frame(VERSION_RST, 32'd10, 32'd4, 4, 1'b0, 0, 19));

    settings[0] = 32'hFFFF_FFFF;
    settings[1] = 32'h0000_0000;
    settings[2] = $urandom;
    settings[3] = $urandom;
    settings[4] = VERSION_RST;

    foreach (settings[p]) begin
      wait_until_idle();
      write_version(settings[p]);
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        pick      = $urandom_range(0, 99);
        len       = $urandom_range(0, 20);
        n_payload = len;
        ver       = version_reg;
        spoil     = 1'b0;
        n_trail   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
        cut       = 0;
        if (pick < 55) begin
          // well-formed frame
        end else if (pick < 65) begin
          ver = $urandom_range(0, 1) ? (version_reg ^ (32'd1 << $urandom_range(0, 31)))
                                     : $urandom;
        end else if (pick < 75) begin
          spoil = 1'b1;
        end else if (pick < 85) begin
          cut = $urandom_range(1, 15 + n_payload + n_trail);
        end else if (pick < 92) begin
          len = $urandom_range(0, 1) ? ($urandom | 32'h8000_0000)
                                     : $urandom_range(40, 32'h7FFF_FFFF);
          n_payload = $urandom_range(0, 12);
        end else begin
          n = $urandom_range(1, 30);
          for (k = 0; k < n; k++) begin
            it.data_byte  = 8'($urandom_range(0, 255));
            it.buffer_end = (k == n - 1);
            bytes_to_send.push_back(it);
          end
          bytes_queued += n;
          phase_bytes  += n;
          continue;
        end
        phase_bytes += queue_frame(ver, $urandom, len, n_payload, spoil, n_trail, cut);
      end
    end

    wait_until_idle();
    if (failures == 0) begin
      $display("crc32_frame_checker: match");
    end else begin
      $display("crc32_frame_checker: mismatch");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/cfc_pkg.sv
rtl/cfc_if.sv
rtl/cfc_parser.sv
rtl/crc32_frame_checker.sv
test/crc32_frame_checker_tb.sv
